// ===== rtl/core/mfrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfrf_pkg;

    // sizes of the stores and of the frame
    localparam int HISTORY_DEPTH  = 10;
    localparam int NEIGHBOR_SLOTS = 10;
    localparam int PAYLOAD_BYTES  = 200;
    localparam int HDR_BYTES      = 6;

    localparam logic [7:0] FRAME_BYTES = 8'(HDR_BYTES + PAYLOAD_BYTES);
    localparam logic [7:0] COUNT_MAX   = 8'hFF;
    localparam logic [7:0] BCAST_ADDR  = 8'hFF;
    localparam logic [7:0] EMPTY_SLOT  = 8'h00;
    localparam logic [7:0] NODE_ID_RST = 8'h01;

    // header byte positions
    localparam logic [7:0] POS_ID_LO = 8'd0;
    localparam logic [7:0] POS_ID_HI = 8'd1;
    localparam logic [7:0] POS_SRC   = 8'd2;
    localparam logic [7:0] POS_DST   = 8'd3;
    localparam logic [7:0] POS_TYPE  = 8'd4;
    localparam logic [7:0] POS_CSUM  = 8'd5;

    // frame type codes
    localparam logic [7:0] FT_DATA   = 8'd2;
    localparam logic [7:0] FT_BEACON = 8'd4;
    localparam logic [7:0] FT_PROBE  = 8'd5;

    typedef enum logic [2:0] {
        VERDICT_BAD_LEN   = 3'd0,
        VERDICT_BAD_CSUM  = 3'd1,
        VERDICT_DUPLICATE = 3'd2,
        VERDICT_ACCEPTED  = 3'd3,
        VERDICT_DROPPED   = 3'd4,
        VERDICT_FORWARDED = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        REPLY_NONE  = 2'd0,
        REPLY_ACK   = 2'd1,
        REPLY_READY = 2'd2
    } reply_kind_t;

    typedef enum logic {
        ST_COLLECT = 1'b0,
        ST_EVAL    = 1'b1
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic take_byte;
        logic evaluate;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mfrf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfrf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_frame_end,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mfrf_pkg::dp_cmd_t      cmd
);

    mfrf_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mfrf_pkg::ST_COLLECT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.evaluate  = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            mfrf_pkg::ST_COLLECT: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
                if (s_valid && s_frame_end) begin
                    state_next = mfrf_pkg::ST_EVAL;
                end
            end
            mfrf_pkg::ST_EVAL: begin
                // wait for a free output slot
                if (!m_valid_reg || m_ready) begin
                    cmd.evaluate = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = mfrf_pkg::ST_COLLECT;
                end
            end
            default: begin
                state_next = mfrf_pkg::ST_COLLECT;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_end_goes_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_end) |=> (state_reg == mfrf_pkg::ST_EVAL))
        else $error("frame end did not start evaluation");
    a_eval_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evaluate |-> (!m_valid_reg || m_ready))
        else $error("verdict would overwrite a pending transaction");
    a_eval_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evaluate |=> m_valid)
        else $error("verdict not presented after evaluation");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mfrf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfrf_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mfrf_pkg::dp_cmd_t cmd,
    input  wire logic [7:0]        frame_byte,
    input  wire logic              cfg_write,
    input  wire logic [7:0]        cfg_node_id,
    output logic [2:0]             verdict,
    output logic [7:0]             frame_type,
    output logic [7:0]             source,
    output logic [7:0]             destination,
    output logic [15:0]            frame_id,
    output logic [1:0]             reply_kind,
    output logic [15:0]            reply_id,
    output logic [7:0]             reply_to,
    output logic                   table_full
);

    logic [7:0]  node_id_reg;
    logic [7:0]  byte_count_reg;
    logic [7:0]  running_xor_reg;
    logic        payload_open_reg;
    logic [15:0] header_id_reg;
    logic [7:0]  header_source_reg;
    logic [7:0]  header_destination_reg;
    logic [7:0]  header_type_reg;
    logic [7:0]  received_checksum_reg;
    logic [15:0] recent_ids_reg [mfrf_pkg::HISTORY_DEPTH];
    logic [7:0]  neighbor_ids_reg [mfrf_pkg::NEIGHBOR_SLOTS];
    logic        probe_pending_reg;
    logic [7:0]  probe_partner_reg;
    logic [15:0] reply_counter_reg;

    logic [2:0]  verdict_reg;
    logic [7:0]  frame_type_reg;
    logic [7:0]  source_reg;
    logic [7:0]  destination_reg;
    logic [15:0] frame_id_reg;
    logic [1:0]  reply_kind_reg;
    logic [15:0] reply_id_reg;
    logic [7:0]  reply_to_reg;
    logic        table_full_reg;

    // evaluation terms
    logic                                dst_known;
    logic                                src_known;
    logic                                id_seen;
    logic                                any_empty;
    logic [mfrf_pkg::NEIGHBOR_SLOTS-1:0] insert_sel;
    mfrf_pkg::verdict_t                  verdict_next;
    mfrf_pkg::reply_kind_t               reply_kind_next;
    logic                                table_full_next;
    logic                                do_insert;
    logic                                do_record;
    logic                                ack_hit;

    always_comb begin
        logic found;
        dst_known = 1'b0;
        src_known = 1'b0;
        id_seen   = 1'b0;
        any_empty = 1'b0;
        found     = 1'b0;
        insert_sel = '0;
        for (int i = 0; i < mfrf_pkg::NEIGHBOR_SLOTS; i++) begin
            if (neighbor_ids_reg[i] == header_destination_reg) dst_known = 1'b1;
            if (neighbor_ids_reg[i] == header_source_reg)      src_known = 1'b1;
            if (neighbor_ids_reg[i] == mfrf_pkg::EMPTY_SLOT) begin
                any_empty = 1'b1;
                if (!found) insert_sel[i] = 1'b1;
                found = 1'b1;
            end
        end
        for (int j = 0; j < mfrf_pkg::HISTORY_DEPTH; j++) begin
            if (recent_ids_reg[j] == header_id_reg) id_seen = 1'b1;
        end
    end

    always_comb begin
        verdict_next    = mfrf_pkg::VERDICT_ACCEPTED;
        reply_kind_next = mfrf_pkg::REPLY_NONE;
        table_full_next = 1'b0;
        do_insert       = 1'b0;
        do_record       = 1'b0;
        ack_hit         = probe_pending_reg && (header_source_reg == probe_partner_reg);
        if (byte_count_reg != mfrf_pkg::FRAME_BYTES) begin
            verdict_next = mfrf_pkg::VERDICT_BAD_LEN;
        end else if (running_xor_reg != received_checksum_reg) begin
            verdict_next = mfrf_pkg::VERDICT_BAD_CSUM;
        end else if (header_destination_reg != node_id_reg &&
                     header_destination_reg != mfrf_pkg::BCAST_ADDR) begin
            verdict_next = dst_known ? mfrf_pkg::VERDICT_FORWARDED
                                     : mfrf_pkg::VERDICT_DROPPED;
        end else if (id_seen) begin
            verdict_next = mfrf_pkg::VERDICT_DUPLICATE;
        end else begin
            do_record = 1'b1;
            if (header_type_reg == mfrf_pkg::FT_BEACON) begin
                do_insert       = !src_known && any_empty;
                table_full_next = !src_known && !any_empty;
            end else if (header_type_reg == mfrf_pkg::FT_DATA) begin
                if (ack_hit) reply_kind_next = mfrf_pkg::REPLY_ACK;
            end else if (header_type_reg == mfrf_pkg::FT_PROBE) begin
                reply_kind_next = mfrf_pkg::REPLY_READY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg            <= mfrf_pkg::NODE_ID_RST;
            byte_count_reg         <= '0;
            running_xor_reg        <= '0;
            payload_open_reg       <= 1'b1;
            header_id_reg          <= '0;
            header_source_reg      <= '0;
            header_destination_reg <= '0;
            header_type_reg        <= '0;
            received_checksum_reg  <= '0;
            for (int i = 0; i < mfrf_pkg::HISTORY_DEPTH; i++) recent_ids_reg[i] <= '0;
            for (int i = 0; i < mfrf_pkg::NEIGHBOR_SLOTS; i++) begin
                neighbor_ids_reg[i] <= mfrf_pkg::EMPTY_SLOT;
            end
            probe_pending_reg      <= 1'b0;
            probe_partner_reg      <= '0;
            reply_counter_reg      <= '0;
        end else begin
            if (cfg_write) node_id_reg <= cfg_node_id;

            if (cmd.take_byte) begin
                case (byte_count_reg)
                    mfrf_pkg::POS_ID_LO: begin
                        header_id_reg[7:0] <= frame_byte;
                        running_xor_reg    <= running_xor_reg ^ frame_byte;
                    end
                    mfrf_pkg::POS_ID_HI: begin
                        header_id_reg[15:8] <= frame_byte;
                        running_xor_reg     <= running_xor_reg ^ frame_byte;
                    end
                    mfrf_pkg::POS_SRC: begin
                        header_source_reg <= frame_byte;
                        running_xor_reg   <= running_xor_reg ^ frame_byte;
                    end
                    mfrf_pkg::POS_DST: begin
                        header_destination_reg <= frame_byte;
                        running_xor_reg        <= running_xor_reg ^ frame_byte;
                    end
                    mfrf_pkg::POS_TYPE: begin
                        header_type_reg <= frame_byte;
                        running_xor_reg <= running_xor_reg ^ frame_byte;
                    end
                    mfrf_pkg::POS_CSUM: begin
                        received_checksum_reg <= frame_byte;
                    end
                    default: begin
                        // payload is summed up to the first zero byte
                        if (byte_count_reg < mfrf_pkg::FRAME_BYTES && payload_open_reg) begin
                            if (frame_byte == 8'h00) payload_open_reg <= 1'b0;
                            else running_xor_reg <= running_xor_reg ^ frame_byte;
                        end
                    end
                endcase
                if (byte_count_reg != mfrf_pkg::COUNT_MAX) begin
                    byte_count_reg <= byte_count_reg + 8'd1;
                end
            end

            if (cmd.evaluate) begin
                if (do_record) begin
                    for (int j = mfrf_pkg::HISTORY_DEPTH - 1; j > 0; j--) begin
                        recent_ids_reg[j] <= recent_ids_reg[j-1];
                    end
                    recent_ids_reg[0] <= header_id_reg;
                end
                if (do_insert) begin
                    for (int i = 0; i < mfrf_pkg::NEIGHBOR_SLOTS; i++) begin
                        if (insert_sel[i]) neighbor_ids_reg[i] <= header_source_reg;
                    end
                end
                if (reply_kind_next == mfrf_pkg::REPLY_ACK) begin
                    probe_pending_reg <= 1'b0;
                    probe_partner_reg <= '0;
                end else if (reply_kind_next == mfrf_pkg::REPLY_READY) begin
                    probe_pending_reg <= 1'b1;
                    probe_partner_reg <= header_source_reg;
                end
                if (reply_kind_next != mfrf_pkg::REPLY_NONE) begin
                    reply_counter_reg <= reply_counter_reg + 16'd1;
                end
                // back to an empty frame
                byte_count_reg         <= '0;
                running_xor_reg        <= '0;
                payload_open_reg       <= 1'b1;
                header_id_reg          <= '0;
                header_source_reg      <= '0;
                header_destination_reg <= '0;
                header_type_reg        <= '0;
                received_checksum_reg  <= '0;
            end
        end
    end

    // result register, loaded once per frame
    always_ff @(posedge aclk) begin
        if (cmd.evaluate) begin
            verdict_reg     <= verdict_next;
            frame_type_reg  <= header_type_reg;
            source_reg      <= header_source_reg;
            destination_reg <= header_destination_reg;
            frame_id_reg    <= header_id_reg;
            reply_kind_reg  <= reply_kind_next;
            table_full_reg  <= table_full_next;
            if (reply_kind_next != mfrf_pkg::REPLY_NONE) begin
                reply_id_reg <= reply_counter_reg;
                reply_to_reg <= header_source_reg;
            end else begin
                reply_id_reg <= '0;
                reply_to_reg <= '0;
            end
        end
    end

    assign verdict     = verdict_reg;
    assign frame_type  = frame_type_reg;
    assign source      = source_reg;
    assign destination = destination_reg;
    assign frame_id    = frame_id_reg;
    assign reply_kind  = reply_kind_reg;
    assign reply_id    = reply_id_reg;
    assign reply_to    = reply_to_reg;
    assign table_full  = table_full_reg;

`ifndef SYNTHESIS
    a_frame_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evaluate |=> (byte_count_reg == '0 && running_xor_reg == '0))
        else $error("frame state not cleared after verdict");
    a_reply_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.evaluate && reply_kind_next != mfrf_pkg::REPLY_NONE)
            |=> (reply_counter_reg == $past(reply_counter_reg) + 16'd1))
        else $error("reply counter did not advance");
    a_insert_one_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(insert_sel))
        else $error("more than one neighbor slot selected for insert");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mac_frame_receive_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                         | direction
// ----------+-----------------------------------------------+----------
// s_        | s_valid s_ready s_frame_byte s_frame_end      | in
// m_        | m_valid m_ready m_verdict ... m_table_full    | out
// cfg_      | cfg_valid cfg_ready cfg_node_id               | in
//
// one byte per cycle while collecting a frame; the byte marked as frame end
// is followed by an evaluation state (parallel history and neighbor compares),
// in which s_ready is low and no byte is taken
// evaluation waits while the previous verdict transaction is still held on m_
// bytes of the next frame are taken while a verdict waits on m_
// synchronous active-low reset clears history and neighbor table at once
module mac_frame_receive_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // frame bytes
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_frame_end,
    // verdicts
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_verdict,
    output logic [7:0]       m_frame_type,
    output logic [7:0]       m_source,
    output logic [7:0]       m_destination,
    output logic [15:0]      m_frame_id,
    output logic [1:0]       m_reply_kind,
    output logic [15:0]      m_reply_id,
    output logic [7:0]       m_reply_to,
    output logic             m_table_full,
    // node address register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_node_id
);

    mfrf_pkg::dp_cmd_t cmd;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing: collect bytes, evaluate, hand verdict to output register
    mfrf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_frame_end (s_frame_end),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    // header capture, checksum, history, neighbor table, reply state
    mfrf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .frame_byte  (s_frame_byte),
        .cfg_write   (cfg_valid),
        .cfg_node_id (cfg_node_id),
        .verdict     (m_verdict),
        .frame_type  (m_frame_type),
        .source      (m_source),
        .destination (m_destination),
        .frame_id    (m_frame_id),
        .reply_kind  (m_reply_kind),
        .reply_id    (m_reply_id),
        .reply_to    (m_reply_to),
        .table_full  (m_table_full)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // frame types with no name in the package
    localparam logic [7:0] FT_START = 8'd1;
    localparam logic [7:0] FT_ACK   = 8'd3;
    localparam logic [7:0] NO_ZERO  = 8'hFF;   // payload carries no zero byte

    localparam int FRAMES_PER_PHASE = 4;
    localparam int NUM_PHASES       = 5;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 600000;

    // sender gap and receiver stall, percent, per random phase
    localparam int PHASE_GAP   [NUM_PHASES] = '{0, 45, 0, 21, 0};
    localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 45, 21, 0};

    typedef struct packed {
        mfrf_pkg::verdict_t    verdict;
        logic [7:0]            frame_type;
        logic [7:0]            source;
        logic [7:0]            destination;
        logic [15:0]           frame_id;
        mfrf_pkg::reply_kind_t reply_kind;
        logic [15:0]           reply_id;
        logic [7:0]            reply_to;
        logic                  table_full;
    } verdict_rec_t;

    // one frame to send; a pinned row carries a verdict known by inspection
    typedef struct packed {
        logic [8:0]         len;
        logic [15:0]        id;
        logic [7:0]         src;
        logic [7:0]         dst;
        logic [7:0]         ftype;
        logic               csum_ok;
        logic [7:0]         zero_at;
        logic               pinned;
        mfrf_pkg::verdict_t want;
    } frame_spec_t;

    localparam int NUM_DIRECTED = 8;
    localparam frame_spec_t DIRECTED_FRAMES [NUM_DIRECTED] = '{
        // history starts all zero, so id 0 is a repeat
        '{9'd206, 16'h0000, 8'd2,   8'd1,   mfrf_pkg::FT_DATA,   1'b1, NO_ZERO, 1'b1,
          mfrf_pkg::VERDICT_DUPLICATE},
        // single byte, then header only
        '{9'd1,   16'h1234, 8'd2,   8'd1,   mfrf_pkg::FT_DATA,   1'b1, NO_ZERO, 1'b1,
          mfrf_pkg::VERDICT_BAD_LEN},
        '{9'd6,   16'h0101, 8'd2,   8'd1,   mfrf_pkg::FT_DATA,   1'b1, NO_ZERO, 1'b1,
          mfrf_pkg::VERDICT_BAD_LEN},
        '{9'd206, 16'h0102, 8'd2,   8'd1,   mfrf_pkg::FT_DATA,   1'b0, 8'd100,  1'b1,
          mfrf_pkg::VERDICT_BAD_CSUM},
        // probe then data from the partner, payload cut at its first and last byte
        '{9'd206, 16'hFFFF, 8'd255, 8'd255, mfrf_pkg::FT_PROBE,  1'b1, 8'd0,    1'b1,
          mfrf_pkg::VERDICT_ACCEPTED},
        '{9'd206, 16'h0001, 8'd255, 8'd1,   mfrf_pkg::FT_DATA,   1'b1, 8'd199,  1'b1,
          mfrf_pkg::VERDICT_ACCEPTED},
        // beacon fills a slot, then that address is forwarded
        '{9'd206, 16'h0006, 8'd77,  8'd255, mfrf_pkg::FT_BEACON, 1'b1, NO_ZERO, 1'b1,
          mfrf_pkg::VERDICT_ACCEPTED},
        '{9'd206, 16'h0007, 8'd5,   8'd77,  FT_ACK,              1'b1, NO_ZERO, 1'b1,
          mfrf_pkg::VERDICT_FORWARDED}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_frame_byte  = 8'h00;
    logic        s_frame_end   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_verdict;
    logic [7:0]  m_frame_type;
    logic [7:0]  m_source;
    logic [7:0]  m_destination;
    logic [15:0] m_frame_id;
    logic [1:0]  m_reply_kind;
    logic [15:0] m_reply_id;
    logic [7:0]  m_reply_to;
    logic        m_table_full;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_node_id   = 8'h00;

    int gap_pct     = 0;
    int stall_pct   = 0;
    int errors      = 0;
    int cycle_count = 0;

    always #1 aclk = ~aclk;

    mac_frame_receive_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_byte  (s_frame_byte),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_frame_type  (m_frame_type),
        .m_source      (m_source),
        .m_destination (m_destination),
        .m_frame_id    (m_frame_id),
        .m_reply_kind  (m_reply_kind),
        .m_reply_id    (m_reply_id),
        .m_reply_to    (m_reply_to),
        .m_table_full  (m_table_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_node_id   (cfg_node_id)
    );

    // ---------------------------------------------------------------
    // filter state as the bench sees it
    // ---------------------------------------------------------------
    logic [7:0]   node_reg;
    logic [7:0]   rx_count;
    logic [7:0]   run_xor;
    logic         payload_live;
    logic [15:0]  hdr_id;
    logic [7:0]   hdr_src;
    logic [7:0]   hdr_dst;
    logic [7:0]   hdr_type;
    logic [7:0]   hdr_csum;
    logic [15:0]  id_history [mfrf_pkg::HISTORY_DEPTH];
    logic [7:0]   neighbors [mfrf_pkg::NEIGHBOR_SLOTS];
    logic         probe_armed;
    logic [7:0]   probe_peer;
    logic [15:0]  reply_seq;

    verdict_rec_t       verdicts_due [$];
    logic               pinned_on = 1'b0;
    mfrf_pkg::verdict_t pinned_verdict;
    logic [7:0]         frame_buf [$];

    function automatic void clear_frame_state();
        rx_count     = 8'h00;
        run_xor      = 8'h00;
        payload_live = 1'b1;
        hdr_id       = 16'h0000;
        hdr_src      = 8'h00;
        hdr_dst      = 8'h00;
        hdr_type     = 8'h00;
        hdr_csum     = 8'h00;
    endfunction

    function automatic void reset_filter_state();
        node_reg = mfrf_pkg::NODE_ID_RST;
        clear_frame_state();
        foreach (id_history[i]) id_history[i] = 16'h0000;
        foreach (neighbors[i]) neighbors[i] = mfrf_pkg::EMPTY_SLOT;
        probe_armed = 1'b0;
        probe_peer  = 8'h00;
        reply_seq   = 16'h0000;
    endfunction

    function automatic logic in_neighbors(input logic [7:0] addr);
        logic hit;
        hit = 1'b0;
        foreach (neighbors[i]) if (neighbors[i] == addr) hit = 1'b1;
        return hit;
    endfunction

    // one accepted byte; on frame end the verdict is queued and the frame cleared
    function automatic void filter_byte(input logic [7:0] b, input logic last);
        verdict_rec_t r;
        logic         dup;
        logic         placed;
        dup    = 1'b0;
        placed = 1'b0;
        case (rx_count)
            mfrf_pkg::POS_ID_LO: begin hdr_id[7:0] = b; run_xor ^= b; end
            mfrf_pkg::POS_ID_HI: begin hdr_id[15:8] = b; run_xor ^= b; end
            mfrf_pkg::POS_SRC:   begin hdr_src = b; run_xor ^= b; end
            mfrf_pkg::POS_DST:   begin hdr_dst = b; run_xor ^= b; end
            mfrf_pkg::POS_TYPE:  begin hdr_type = b; run_xor ^= b; end
            mfrf_pkg::POS_CSUM:  hdr_csum = b;
            default: begin
                // payload sums up to its first zero; bytes past the frame size are ignored
                if (rx_count < mfrf_pkg::FRAME_BYTES && payload_live) begin
                    if (b == 8'h00) payload_live = 1'b0;
                    else run_xor ^= b;
                end
            end
        endcase
        if (rx_count != mfrf_pkg::COUNT_MAX) rx_count++;
        if (!last) return;

        r             = '0;
        r.frame_type  = hdr_type;
        r.source      = hdr_src;
        r.destination = hdr_dst;
        r.frame_id    = hdr_id;
        if (rx_count != mfrf_pkg::FRAME_BYTES) begin
            r.verdict = mfrf_pkg::VERDICT_BAD_LEN;
        end else if (run_xor != hdr_csum) begin
            r.verdict = mfrf_pkg::VERDICT_BAD_CSUM;
        end else if (hdr_dst != node_reg && hdr_dst != mfrf_pkg::BCAST_ADDR) begin
            r.verdict = in_neighbors(hdr_dst) ? mfrf_pkg::VERDICT_FORWARDED
                                              : mfrf_pkg::VERDICT_DROPPED;
        end else begin
            foreach (id_history[i]) if (id_history[i] == hdr_id) dup = 1'b1;
            if (dup) begin
                r.verdict = mfrf_pkg::VERDICT_DUPLICATE;
            end else begin
                for (int i = mfrf_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
                    id_history[i] = id_history[i - 1];
                end
                id_history[0] = hdr_id;
                r.verdict = mfrf_pkg::VERDICT_ACCEPTED;
                if (hdr_type == mfrf_pkg::FT_BEACON) begin
                    if (!in_neighbors(hdr_src)) begin
                        foreach (neighbors[i]) begin
                            if (!placed && neighbors[i] == mfrf_pkg::EMPTY_SLOT) begin
                                neighbors[i] = hdr_src;
                                placed = 1'b1;
                            end
                        end
                        r.table_full = !placed;
                    end
                end else if (hdr_type == mfrf_pkg::FT_DATA) begin
                    if (probe_armed && hdr_src == probe_peer) begin
                        r.reply_kind = mfrf_pkg::REPLY_ACK;
                        r.reply_id   = reply_seq;
                        r.reply_to   = hdr_src;
                        reply_seq++;
                        probe_armed  = 1'b0;
                        probe_peer   = 8'h00;
                    end
                end else if (hdr_type == mfrf_pkg::FT_PROBE) begin
                    probe_armed  = 1'b1;
                    probe_peer   = hdr_src;
                    r.reply_kind = mfrf_pkg::REPLY_READY;
                    r.reply_id   = reply_seq;
                    r.reply_to   = hdr_src;
                    reply_seq++;
                end
            end
        end
        if (pinned_on) begin
            r.verdict = pinned_verdict;
            pinned_on = 1'b0;
        end
        verdicts_due.push_back(r);
        clear_frame_state();
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_verdict();
        verdict_rec_t want;
        if (verdicts_due.size() == 0) begin
            $error("verdict transaction with no frame end pending");
            errors++;
        end else begin
            want = verdicts_due.pop_front();
            check_field("verdict", 16'(want.verdict), 16'(m_verdict));
            check_field("frame_type", 16'(want.frame_type), 16'(m_frame_type));
            check_field("source", 16'(want.source), 16'(m_source));
            check_field("destination", 16'(want.destination), 16'(m_destination));
            check_field("frame_id", want.frame_id, m_frame_id);
            check_field("reply_kind", 16'(want.reply_kind), 16'(m_reply_kind));
            check_field("reply_id", want.reply_id, m_reply_id);
            check_field("reply_to", 16'(want.reply_to), 16'(m_reply_to));
            check_field("table_full", 16'(want.table_full), 16'(m_table_full));
        end
    endtask

    // all three channels sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) node_reg = cfg_node_id;
            if (s_valid && s_ready) filter_byte(s_frame_byte, s_frame_end);
            if (m_valid && m_ready) check_verdict();
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic void build_frame(input frame_spec_t f);
        logic [7:0] csum_acc;
        logic [7:0] b;
        logic       live;
        frame_buf = '{f.id[7:0], f.id[15:8], f.src, f.dst, f.ftype, 8'h00};
        csum_acc  = f.id[7:0] ^ f.id[15:8] ^ f.src ^ f.dst ^ f.ftype;
        live      = 1'b1;
        for (int i = 0; i < mfrf_pkg::PAYLOAD_BYTES; i++) begin
            if (i == f.zero_at) b = 8'h00;
            else if (live) b = 8'($urandom_range(255, 1));
            else b = 8'($urandom_range(255, 0));
            if (live) begin
                if (b == 8'h00) live = 1'b0;
                else csum_acc ^= b;
            end
            frame_buf.push_back(b);
        end
        frame_buf[mfrf_pkg::POS_CSUM] = f.csum_ok ? csum_acc
                                                  : csum_acc ^ 8'($urandom_range(255, 1));
        while (frame_buf.size() > f.len) void'(frame_buf.pop_back());
        while (frame_buf.size() < f.len) frame_buf.push_back(8'($urandom_range(255, 0)));
    endfunction

    // short frames with random headers keep the byte count low: each one fails
    // the length check, while the captured header fields come back on the verdict
    function automatic frame_spec_t rand_frame();
        frame_spec_t f;
        int unsigned pick;
        f = '0;
        f.id = ($urandom_range(99) < 60) ? 16'($urandom_range(11)) * 16'h0101
                                          : 16'($urandom);
        pick = $urandom_range(99);
        f.src = (pick < 55) ? 8'($urandom_range(14, 1)) :
                (pick < 65) ? 8'h00 :
                (pick < 75) ? mfrf_pkg::BCAST_ADDR : 8'($urandom);
        pick = $urandom_range(99);
        f.dst = (pick < 35) ? node_reg :
                (pick < 55) ? mfrf_pkg::BCAST_ADDR :
                (pick < 75) ? 8'($urandom_range(14, 1)) :
                (pick < 85) ? 8'h00 : 8'($urandom);
        f.ftype   = ($urandom_range(99) < 85) ? 8'($urandom_range(5, 1)) : 8'($urandom);
        f.csum_ok = ($urandom_range(99) < 90);
        f.zero_at = ($urandom_range(99) < 60) ? NO_ZERO
                                               : 8'($urandom_range(mfrf_pkg::PAYLOAD_BYTES - 1));
        f.len     = 9'($urandom_range(7, 1));
        f.pinned  = 1'b0;
        f.want    = mfrf_pkg::VERDICT_ACCEPTED;
        return f;
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_frame_end  <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_frame(input frame_spec_t f);
        build_frame(f);
        pinned_on      = f.pinned;
        pinned_verdict = f.want;
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // sender quiet until every verdict is out, then a settling wait for the evaluation slot
    task automatic drain();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_node(input logic [7:0] addr);
        cfg_valid   <= 1'b1;
        cfg_node_id <= addr;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] addr;
        reset_filter_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames run at the reset node address
        foreach (DIRECTED_FRAMES[i]) send_frame(DIRECTED_FRAMES[i]);

        // random phases: node address extremes first, then random, then back to reset value
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0:       addr = 8'd0;
                1:       addr = 8'd254;
                NUM_PHASES - 1: addr = mfrf_pkg::NODE_ID_RST;
                default: addr = 8'($urandom_range(253, 2));
            endcase
            write_node(addr);
            gap_pct   = PHASE_GAP[p];
            stall_pct = PHASE_STALL[p];
            repeat (FRAMES_PER_PHASE) send_frame(rand_frame());
        end
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
